// ===== hdl/lrl_pkg.sv =====
`default_nettype none
// ---------------------------------------------------------------------------
// lrl_pkg
// Shared types and constants of the LRU recency list: opcodes, status codes
// and the packed payloads of the request and result channels.
// ---------------------------------------------------------------------------
package lrl_pkg;

  localparam int SLOTS   = 16;
  localparam int DATA_W  = 32;
  localparam int SLOT_W  = $clog2(SLOTS);
  localparam int COUNT_W = $clog2(SLOTS + 1);

  localparam logic [COUNT_W-1:0] CAP_RESET = COUNT_W'(SLOTS);

  typedef enum logic [1:0] {
    OP_INSERT = 2'd0,
    OP_REMOVE = 2'd1,
    OP_TOUCH  = 2'd2,
    OP_NOP    = 2'd3
  } lrl_op_t;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_EMPTY    = 2'd1,
    ST_BAD_SLOT = 2'd2
  } lrl_status_t;

  typedef struct packed {
    lrl_op_t            opcode;
    logic [DATA_W-1:0]  payload;
    logic [SLOT_W-1:0]  slot;
  } lrl_in_t;

  typedef struct packed {
    lrl_status_t        status;
    logic [SLOT_W-1:0]  slot_out;
    logic [DATA_W-1:0]  payload_out;
    logic               evicted;
    logic [COUNT_W-1:0] entry_count;
  } lrl_out_t;

endpackage
`default_nettype wire

// ===== hdl/lrl_list.sv =====
`default_nettype none
// ---------------------------------------------------------------------------
// lrl_list
// Linked list state (payloads, links, occupancy, head, tail, count) and the
// single-pass logic that applies one operation and forms its result.
// ---------------------------------------------------------------------------
module lrl_list
  import lrl_pkg::*;
(
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                cfg_wr_en,
  input  wire logic [COUNT_W-1:0]  cfg_wr_data,
  input  wire logic                go,
  input  wire lrl_in_t             item,
  output lrl_out_t                 res
);

  logic [DATA_W-1:0]  payload_r [SLOTS];
  logic [SLOT_W-1:0]  next_r    [SLOTS];
  logic [SLOT_W-1:0]  prev_r    [SLOTS];
  logic [SLOTS-1:0]   used_r,   used_nxt;
  logic [SLOT_W-1:0]  head_r,   head_nxt;
  logic [SLOT_W-1:0]  tail_r,   tail_nxt;
  logic [COUNT_W-1:0] count_r,  count_nxt;
  logic [COUNT_W-1:0] capacity_r;

  logic [COUNT_W-1:0] eff_cap;
  logic               is_ins, is_rem, is_touch;
  logic [SLOT_W-1:0]  prev_addr, prev_rd, next_rd;
  logic [DATA_W-1:0]  tail_payload;
  logic               pop, pop_last, ins_link;
  logic [COUNT_W-1:0] cnt_pop;
  logic [SLOT_W-1:0]  tail_pop, head_pop, free_slot;
  logic [SLOTS-1:0]   used_pop;
  logic               t_ok, t_move, t_tail;

  always_comb begin
    if (capacity_r == '0) begin
      eff_cap = COUNT_W'(1);
    end else if (capacity_r > COUNT_W'(SLOTS)) begin
      eff_cap = COUNT_W'(SLOTS);
    end else begin
      eff_cap = capacity_r;
    end
  end

  assign is_ins   = (item.opcode == OP_INSERT);
  assign is_rem   = (item.opcode == OP_REMOVE);
  assign is_touch = (item.opcode == OP_TOUCH);

  // prev link is needed at the tail for a pop, at the touched slot for a move
  assign prev_addr    = is_touch ? item.slot : tail_r;
  assign prev_rd      = prev_r[prev_addr];
  assign next_rd      = next_r[item.slot];
  assign tail_payload = payload_r[tail_r];

  assign pop      = (count_r != '0) &&
                    (is_rem || (is_ins && (count_r >= eff_cap)));
  assign pop_last = (count_r <= COUNT_W'(1));
  assign cnt_pop  = count_r - COUNT_W'(pop);
  assign tail_pop = pop ? (pop_last ? '0 : prev_rd) : tail_r;
  assign head_pop = (pop && pop_last) ? '0 : head_r;
  assign used_pop = used_r & ~(pop ? (SLOTS'(1) << tail_r) : '0);
  assign ins_link = (cnt_pop != '0);

  // lowest free slot after a possible eviction
  always_comb begin
    free_slot = '0;
    for (int i = SLOTS - 1; i >= 0; i--) begin
      if (!used_pop[i]) free_slot = SLOT_W'(i);
    end
  end

  assign t_ok   = used_r[item.slot];
  assign t_move = t_ok && (item.slot != head_r);
  assign t_tail = (item.slot == tail_r);

  always_comb begin
    used_nxt  = used_r;
    head_nxt  = head_r;
    tail_nxt  = tail_r;
    count_nxt = count_r;
    unique case (item.opcode)
      OP_INSERT: begin
        used_nxt  = used_pop | (SLOTS'(1) << free_slot);
        count_nxt = cnt_pop + COUNT_W'(1);
        head_nxt  = free_slot;
        tail_nxt  = ins_link ? tail_pop : free_slot;
      end
      OP_REMOVE: begin
        used_nxt  = used_pop;
        count_nxt = cnt_pop;
        head_nxt  = head_pop;
        tail_nxt  = tail_pop;
      end
      OP_TOUCH: begin
        if (t_move) begin
          head_nxt = item.slot;
          if (t_tail) tail_nxt = prev_rd;
        end
      end
      OP_NOP: begin
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    res.status      = ST_OK;
    res.slot_out    = '0;
    res.payload_out = pop ? tail_payload : '0;
    res.evicted     = pop;
    res.entry_count = count_nxt;
    unique case (item.opcode)
      OP_INSERT: res.slot_out = free_slot;
      OP_REMOVE: begin
        if (count_r == '0) res.status = ST_EMPTY;
        else res.slot_out = tail_r;
      end
      OP_TOUCH: begin
        res.slot_out = item.slot;
        if (!t_ok) res.status = ST_BAD_SLOT;
      end
      OP_NOP: begin
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      used_r     <= '0;
      head_r     <= '0;
      tail_r     <= '0;
      count_r    <= '0;
      capacity_r <= CAP_RESET;
    end else begin
      if (cfg_wr_en) capacity_r <= cfg_wr_data;
      if (go) begin
        used_r  <= used_nxt;
        head_r  <= head_nxt;
        tail_r  <= tail_nxt;
        count_r <= count_nxt;
      end
    end
  end

  // payload and link stores: no reset, only entries in use are ever read
  always_ff @(posedge clk) begin
    if (go) begin
      for (int i = 0; i < SLOTS; i++) begin
        if (is_ins) begin
          if (free_slot == SLOT_W'(i)) begin
            payload_r[i] <= item.payload;
            if (ins_link) next_r[i] <= head_r;
          end
          if (ins_link && (head_r == SLOT_W'(i))) prev_r[i] <= free_slot;
        end
        if (is_touch && t_move) begin
          // unlink from the middle, then relink at the head
          if (!t_tail && (prev_rd == SLOT_W'(i))) next_r[i] <= next_rd;
          if (!t_tail && (next_rd == SLOT_W'(i))) prev_r[i] <= prev_rd;
          if (item.slot == SLOT_W'(i)) next_r[i] <= head_r;
          if (head_r == SLOT_W'(i)) prev_r[i] <= item.slot;
        end
      end
    end
  end

endmodule
`default_nettype wire

// ===== hdl/lru_recency_list.sv =====
`default_nettype none
// A request is held in the request register and its result in the result register.
// Throughput: one operation per cycle while the output is not stalled; the link update of each
// operation is a single combinational pass between the request register and the result register.
// Reset (rst_n low at a clock edge) empties the list, clears the valid flags of both
// pipeline registers and sets capacity to 16; no clearing pass, ready the next cycle.
// ---------------------------------------------------------------------------
// lru_recency_list
// Bounded doubly linked recency list for LRU replacement: insert at front
// with tail eviction, remove tail, move slot to front.
// ---------------------------------------------------------------------------
module lru_recency_list
  import lrl_pkg::*;
(
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                cfg_wr_en,
  input  wire logic [COUNT_W-1:0]  cfg_wr_data,
  input  wire logic                in_valid,
  output logic                     in_stall,
  input  wire lrl_in_t             in_data,
  output logic                     out_valid,
  input  wire logic                out_stall,
  output lrl_out_t                 out_data
);

  logic     req_valid_r, req_valid_nxt;
  lrl_in_t  req_r;
  logic     res_valid_r, res_valid_nxt;
  lrl_out_t res_r;
  lrl_out_t res_comb;
  logic     res_free, go, in_take;

  assign res_free = !res_valid_r || !out_stall;
  assign go       = req_valid_r && res_free;
  assign in_stall = req_valid_r && !res_free;
  assign in_take  = in_valid && !in_stall;

  assign req_valid_nxt = in_take || (req_valid_r && !go);
  assign res_valid_nxt = go || (res_valid_r && !res_free);

  lrl_list u_list (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .go          (go),
    .item        (req_r),
    .res         (res_comb)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      req_valid_r <= 1'b0;
      res_valid_r <= 1'b0;
    end else begin
      req_valid_r <= req_valid_nxt;
      res_valid_r <= res_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) req_r <= in_data;
    if (go) res_r <= res_comb;
  end

  assign out_valid = res_valid_r;
  assign out_data  = res_r;

endmodule
`default_nettype wire

// ===== hdl/lrl_checker.sv =====
`default_nettype none
// ---------------------------------------------------------------------------
// lrl_checker
// Port-level checks on the result channel of the LRU recency list.
// ---------------------------------------------------------------------------
module lrl_checker
  import lrl_pkg::*;
(
  input wire logic     clk,
  input wire logic     rst_n,
  input wire logic     out_valid,
  input wire logic     out_stall,
  input wire lrl_out_t out_data
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("stalled result changed or dropped");

  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid right after reset");

  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_data.entry_count <= COUNT_W'(SLOTS))
    else $error("entry count above slot count");

  a_empty_result: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_data.status == ST_EMPTY)
      |-> !out_data.evicted && (out_data.entry_count == '0))
    else $error("empty status with eviction or nonzero count");

  a_evict_ok: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.evicted |-> out_data.status == ST_OK)
    else $error("eviction reported with error status");

endmodule

bind lru_recency_list lrl_checker u_lrl_checker (.*);
`default_nettype wire
